/* hdl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] LVL_SERIOUS = 2'd1;
  localparam logic [1:0] LVL_MEDIUM  = 2'd2;
  localparam logic [1:0] LVL_GENERAL = 2'd3;
  localparam logic [1:0] LVL_NONE    = 2'd0;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_ENQ_HEAD,
    ST_DEQ_HEAD,
    ST_DEQ_SHIFT
  } state_e;

  typedef struct packed {
    logic               func;
    logic signed [31:0] item_value;
    logic [1:0]         item_level;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [1:0]         out_level;
    logic [4:0]         occupancy;
  } out_t;

  typedef struct packed {
    logic [1:0]             level;
    logic [VALUE_WIDTH-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

/* hdl/spq_ram.sv */
`default_nettype none

module spq_ram (
  input  logic              clk_i,
  input  spq_pkg::ram_req_t req_i,
  output spq_pkg::entry_t   rd_data_o
);
  import spq_pkg::*;

  entry_t mem_q [CAPACITY];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* hdl/stable_priority_queue.sv */
// Full-store enqueue, empty-store dequeue and enqueue into an empty store: result registered
// in the cycle after acceptance. Other enqueues move each less urgent entry back one slot;
// dequeue moves each entry behind the head forward. One entry moves per cycle through the
// single read and single write port of the slot memory, on enqueue compared against the new
// level by one shared comparator. The next transaction is accepted in the cycle a result is taken.
// Reset (asynchronous, active low) empties the queue; slot contents are not cleared.
`default_nettype none

module stable_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::out_t out_o
);
  import spq_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  entry_t           new_q, new_d;
  entry_t           head_q, head_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  ram_req_t         ram_req;
  entry_t           rd_data;
  entry_t           in_entry;
  logic             in_fire;

  spq_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A level of zero is taken as general.
  assign in_entry.level = (in_i.item_level == LVL_NONE) ? LVL_GENERAL : in_i.item_level;
  assign in_entry.value = VALUE_WIDTH'($unsigned(in_i.item_value));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    new_q  <= new_d;
    head_q <= head_d;
    out_q  <= out_d;
  end

  always_comb begin
    logic    fin;
    status_e fin_status;
    entry_t  fin_entry;

    fin         = 1'b0;
    fin_status  = STS_OK;
    fin_entry   = '0;
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    new_d       = new_q;
    head_d      = head_q;
    ram_req     = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          new_d = in_entry;
          if (in_i.func == FUNC_ENQ) begin
            if (count_q >= CNT_W'(CAPACITY)) begin
              fin        = 1'b1;
              fin_status = STS_FULL;
            end else if (count_q == '0) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = '0;
              ram_req.wdata = in_entry;
              count_d       = CNT_W'(1);
              fin           = 1'b1;
            end else begin
              idx_d         = IDX_W'(count_q);
              ram_req.re    = 1'b1;
              ram_req.raddr = IDX_W'(count_q - CNT_W'(1));
              state_d       = ST_ENQ;
            end
          end else begin
            if (count_q == '0) begin
              fin        = 1'b1;
              fin_status = STS_EMPTY;
            end else begin
              ram_req.re    = 1'b1;
              ram_req.raddr = '0;
              state_d       = ST_DEQ_HEAD;
            end
          end
        end
      end

      // Walk from the back: each stored entry less urgent than the new one moves back a slot.
      ST_ENQ: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_q;
        if (rd_data.level <= new_q.level) begin
          ram_req.wdata = new_q;
          count_d       = count_q + CNT_W'(1);
          fin           = 1'b1;
        end else begin
          ram_req.wdata = rd_data;
          if (idx_q == IDX_W'(1)) begin
            state_d = ST_ENQ_HEAD;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = idx_q - IDX_W'(2);
            idx_d         = idx_q - IDX_W'(1);
          end
        end
      end

      ST_ENQ_HEAD: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = new_q;
        count_d       = count_q + CNT_W'(1);
        fin           = 1'b1;
      end

      ST_DEQ_HEAD: begin
        head_d = rd_data;
        if (count_q == CNT_W'(1)) begin
          count_d   = '0;
          fin       = 1'b1;
          fin_entry = rd_data;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = IDX_W'(1);
          idx_d         = '0;
          state_d       = ST_DEQ_SHIFT;
        end
      end

      // Each remaining entry moves forward one slot.
      ST_DEQ_SHIFT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_q;
        ram_req.wdata = rd_data;
        if ((CNT_W'(idx_q) + CNT_W'(2)) == count_q) begin
          count_d   = count_q - CNT_W'(1);
          fin       = 1'b1;
          fin_entry = head_q;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_q + IDX_W'(2);
          idx_d         = idx_q + IDX_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_d         = ST_IDLE;
      out_valid_d     = 1'b1;
      out_d.status    = fin_status;
      out_d.out_value = 32'(fin_entry.value);
      out_d.out_level = fin_entry.level;
      out_d.occupancy = 5'(count_d);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("result pending while a transaction is in progress");

  a_occ_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.occupancy == 5'(count_q)))
    else $error("reported occupancy differs from the entry count");

  a_empty_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.func == FUNC_DEQ) && (count_q == '0))
      |=> (out_valid_q && (out_q.status == STS_EMPTY)))
    else $error("dequeue on an empty queue did not report empty");
`endif

endmodule

`default_nettype wire
